@@ sv/cnsm_pkg.sv @@
// Shared types and constants of the caller number suffix matcher.
package cnsm_pkg;

  localparam logic [2:0] REQ_WRITE  = 3'd0;
  localparam logic [2:0] REQ_CLEAR  = 3'd1;
  localparam logic [2:0] REQ_HEADER = 3'd2;
  localparam logic [2:0] REQ_CALLER = 3'd3;
  localparam logic [2:0] REQ_MATCH  = 3'd4;

  localparam logic [7:0] QUOTE_CHAR = 8'h22;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] NUL_CHAR   = 8'h00;
  localparam logic [7:0] EMPTY_BYTE = 8'hFF;

  localparam int CALLER_BYTES = 16;
  localparam int NUM_START    = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_HDR0,
    ST_HDR1,
    ST_HDR2,
    ST_QSRCH,
    ST_CWIN,
    ST_SCAN,
    ST_DRAIN,
    ST_CHECK,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic caller_we;
    logic rec_we;
    logic clr_we;
    logic pos_clr;
    logic pos_scan;
    logic pos_inc;
    logic hdr_rd0;
    logic hdr_rd1;
    logic cap_cat;
    logic cap_mode;
    logic scan_rd;
    logic qsrch;
    logic cwin_we;
    logic rec_inc;
    logic chk;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       idx_ok;
    logic       pos_last;
    logic       k_last;
    logic       rec_last;
    logic       match;
    logic       out_busy;
  } sts_t;

endpackage

@@ sv/cnsm_ram.sv @@
// Generic single-port-write, registered-read RAM.
module cnsm_ram #(
  parameter int W = 8,
  parameter int D = 240
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ sv/cnsm_ctrl.sv @@
// Controller state machine that sequences requests through the datapath.
module cnsm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  cnsm_pkg::sts_t sts_i,
  output cnsm_pkg::cmd_t cmd_o
);

  cnsm_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cnsm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cnsm_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = cnsm_pkg::ST_DECODE;
      end
      cnsm_pkg::ST_DECODE: begin
        unique case (sts_i.req)
          cnsm_pkg::REQ_CLEAR:  state_d = sts_i.idx_ok ? cnsm_pkg::ST_CLEAR : cnsm_pkg::ST_IDLE;
          cnsm_pkg::REQ_HEADER: state_d = cnsm_pkg::ST_HDR0;
          cnsm_pkg::REQ_MATCH:  state_d = cnsm_pkg::ST_QSRCH;
          default:              state_d = cnsm_pkg::ST_IDLE;
        endcase
      end
      cnsm_pkg::ST_CLEAR: begin
        if (sts_i.pos_last) state_d = cnsm_pkg::ST_IDLE;
      end
      cnsm_pkg::ST_HDR0:  state_d = cnsm_pkg::ST_HDR1;
      cnsm_pkg::ST_HDR1:  state_d = cnsm_pkg::ST_HDR2;
      cnsm_pkg::ST_HDR2:  state_d = cnsm_pkg::ST_DONE;
      cnsm_pkg::ST_QSRCH: state_d = cnsm_pkg::ST_CWIN;
      cnsm_pkg::ST_CWIN: begin
        if (sts_i.k_last) state_d = cnsm_pkg::ST_SCAN;
      end
      cnsm_pkg::ST_SCAN: begin
        if (sts_i.pos_last) state_d = cnsm_pkg::ST_DRAIN;
      end
      cnsm_pkg::ST_DRAIN: state_d = cnsm_pkg::ST_CHECK;
      cnsm_pkg::ST_CHECK: begin
        if (sts_i.match || sts_i.rec_last) begin
          state_d = cnsm_pkg::ST_DONE;
        end else begin
          state_d = cnsm_pkg::ST_SCAN;
        end
      end
      cnsm_pkg::ST_DONE: begin
        if (!sts_i.out_busy) state_d = cnsm_pkg::ST_IDLE;
      end
      default: state_d = cnsm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      cnsm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.accept  = s_axis_tvalid;
      end
      cnsm_pkg::ST_DECODE: begin
        cmd_o.pos_clr   = 1'b1;
        cmd_o.rec_we    = (sts_i.req == cnsm_pkg::REQ_WRITE);
        cmd_o.caller_we = (sts_i.req == cnsm_pkg::REQ_CALLER);
      end
      cnsm_pkg::ST_CLEAR: begin
        cmd_o.clr_we  = 1'b1;
        cmd_o.pos_inc = 1'b1;
      end
      cnsm_pkg::ST_HDR0: cmd_o.hdr_rd0 = 1'b1;
      cnsm_pkg::ST_HDR1: begin
        cmd_o.hdr_rd1 = 1'b1;
        cmd_o.cap_cat = 1'b1;
      end
      cnsm_pkg::ST_HDR2: cmd_o.cap_mode = 1'b1;
      cnsm_pkg::ST_QSRCH: cmd_o.qsrch = 1'b1;
      cnsm_pkg::ST_CWIN: begin
        cmd_o.cwin_we  = 1'b1;
        cmd_o.pos_scan = sts_i.k_last;
      end
      cnsm_pkg::ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        cmd_o.pos_inc = 1'b1;
      end
      cnsm_pkg::ST_DRAIN: ;
      cnsm_pkg::ST_CHECK: begin
        cmd_o.chk = 1'b1;
        if (!sts_i.match && !sts_i.rec_last) begin
          cmd_o.rec_inc  = 1'b1;
          cmd_o.pos_scan = 1'b1;
        end
      end
      cnsm_pkg::ST_DONE: cmd_o.out_load = !sts_i.out_busy;
      default: ;
    endcase
  end

endmodule

@@ sv/cnsm_dp.sv @@
// Datapath: record RAM, caller buffer, compare windows and output register.
module cnsm_dp #(
  parameter int ENTRIES      = 15,
  parameter int RECORD_BYTES = 16,
  parameter int MATCH_CHARS  = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    s_axis_tdata,
  input  logic [2:0]     s_axis_tuser,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [23:0]    m_axis_tdata,
  output logic           m_axis_tuser,
  input  cnsm_pkg::cmd_t cmd_i,
  output cnsm_pkg::sts_t sts_o
);

  localparam int D    = ENTRIES * RECORD_BYTES;
  localparam int AW   = $clog2(D);
  localparam int PW   = $clog2(RECORD_BYTES);
  localparam int EW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KW   = (MATCH_CHARS > 1) ? $clog2(MATCH_CHARS) : 1;
  localparam logic [AW-1:0] RB_A = AW'(RECORD_BYTES);

  // Latched request.
  logic [2:0] req_q;
  logic [3:0] idx_q, bpos_q;
  logic [7:0] bval_q;
  logic       idx_ok, pos_ok;

  logic [PW-1:0] pos_q;
  logic [EW-1:0] rec_q;
  logic [KW-1:0] k_q;
  logic [3:0]    last_q, last_d;

  logic [7:0] caller_q [cnsm_pkg::CALLER_BYTES];
  logic [7:0] cwin_q [MATCH_CHARS];
  logic [MATCH_CHARS-1:0] cok_q;
  logic [7:0] rwin_q [MATCH_CHARS];

  logic [PW-1:0] cnt_q, cnt_d;
  logic          skip_q, skip_d, done_q, done_d;
  logic          scan_vld_q, scan_first_q;
  logic          shift_en;

  logic [7:0] hdr_cat_q, hdr_mode_q;
  logic       found_q;

  logic       out_vld_q;
  logic [23:0] out_data_q;
  logic       out_kind_q;

  // RAM ports.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  logic [AW+3:0] idx_w, bpos_w;
  logic [AW+PW-1:0] pos_w;
  logic [AW+EW-1:0] rec_w;
  logic [AW-1:0] idx_base, rec_base;
  logic [KW+3:0] k_w;
  logic [3:0]    k4;
  logic [EW+3:0] rec_x;
  logic          term;
  logic          eq_all;

  assign idx_ok = int'(idx_q) < ENTRIES;
  assign pos_ok = int'(bpos_q) < RECORD_BYTES;

  assign idx_w    = {{AW{1'b0}}, idx_q};
  assign bpos_w   = {{AW{1'b0}}, bpos_q};
  assign pos_w    = {{AW{1'b0}}, pos_q};
  assign rec_w    = {{AW{1'b0}}, rec_q};
  assign idx_base = idx_w[AW-1:0] * RB_A;
  assign rec_base = rec_w[AW-1:0] * RB_A;
  assign k_w      = {4'b0000, k_q};
  assign k4       = k_w[3:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_base + pos_w[AW-1:0];
    ram_wdata = bval_q;
    if (cmd_i.rec_we) begin
      ram_we    = idx_ok && pos_ok;
      ram_waddr = idx_base + bpos_w[AW-1:0];
    end else if (cmd_i.clr_we) begin
      ram_we = 1'b1;
      if (int'(pos_q) < cnsm_pkg::NUM_START) begin
        ram_wdata = cnsm_pkg::ZERO_CHAR;
      end else if (int'(pos_q) == cnsm_pkg::NUM_START) begin
        ram_wdata = cnsm_pkg::NUL_CHAR;
      end else begin
        ram_wdata = cnsm_pkg::EMPTY_BYTE;
      end
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = rec_base + pos_w[AW-1:0];
    if (cmd_i.hdr_rd0) begin
      ram_re    = idx_ok;
      ram_raddr = idx_base;
    end else if (cmd_i.hdr_rd1) begin
      ram_re    = idx_ok;
      ram_raddr = idx_base + AW'(1);
    end else if (cmd_i.scan_rd) begin
      ram_re = 1'b1;
    end
  end

  cnsm_ram #(
    .W(8),
    .D(D)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // The compared caller characters end just before the first quote at 1..15.
  always_comb begin
    last_d = 4'd15;
    for (int p = cnsm_pkg::CALLER_BYTES - 1; p >= 1; p--) begin
      if (caller_q[p] == cnsm_pkg::QUOTE_CHAR) last_d = 4'(p - 1);
    end
  end

  // Record bytes stream in order; the window keeps the last characters
  // seen before the terminator, newest at position zero.
  assign term = (ram_rdata == cnsm_pkg::QUOTE_CHAR) || (ram_rdata == cnsm_pkg::NUL_CHAR);

  always_comb begin
    skip_d   = skip_q;
    done_d   = done_q;
    cnt_d    = cnt_q;
    shift_en = 1'b0;
    if (scan_vld_q) begin
      if (scan_first_q) begin
        skip_d   = (ram_rdata == cnsm_pkg::EMPTY_BYTE);
        done_d   = term;
        cnt_d    = term ? '0 : PW'(1);
        shift_en = !term;
      end else if (!done_q) begin
        if (term) begin
          done_d = 1'b1;
        end else begin
          shift_en = 1'b1;
          cnt_d    = cnt_q + PW'(1);
        end
      end
    end
  end

  always_comb begin
    eq_all = 1'b1;
    for (int k = 0; k < MATCH_CHARS; k++) begin
      if (!cok_q[k] || (cwin_q[k] != rwin_q[k])) eq_all = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q  <= s_axis_tuser;
      idx_q  <= s_axis_tdata[3:0];
      bpos_q <= s_axis_tdata[7:4];
      bval_q <= s_axis_tdata[15:8];
    end
    if (cmd_i.caller_we) caller_q[bpos_q] <= bval_q;
    if (cmd_i.qsrch) last_q <= last_d;
    if (cmd_i.cwin_we) begin
      cwin_q[k_q] <= caller_q[last_q - k4];
      cok_q[k_q]  <= (k4 <= last_q);
    end
    if (shift_en) begin
      rwin_q[0] <= ram_rdata;
      for (int k = 1; k < MATCH_CHARS; k++) rwin_q[k] <= rwin_q[k-1];
    end
    skip_q <= skip_d;
    done_q <= done_d;
    cnt_q  <= cnt_d;
    if (cmd_i.cap_cat)  hdr_cat_q  <= idx_ok ? ram_rdata : 8'h00;
    if (cmd_i.cap_mode) hdr_mode_q <= idx_ok ? ram_rdata : 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      rec_q        <= '0;
      k_q          <= '0;
      found_q      <= 1'b0;
      scan_vld_q   <= 1'b0;
      scan_first_q <= 1'b0;
    end else begin
      scan_vld_q   <= cmd_i.scan_rd;
      scan_first_q <= cmd_i.scan_rd && (int'(pos_q) == cnsm_pkg::NUM_START);
      if (cmd_i.pos_clr) begin
        pos_q <= '0;
      end else if (cmd_i.pos_scan) begin
        pos_q <= PW'(cnsm_pkg::NUM_START);
      end else if (cmd_i.pos_inc) begin
        pos_q <= pos_q + PW'(1);
      end
      if (cmd_i.qsrch) begin
        rec_q   <= '0;
        k_q     <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.rec_inc) rec_q <= rec_q + EW'(1);
        if (cmd_i.cwin_we) k_q <= k_q + KW'(1);
        if (cmd_i.chk) found_q <= sts_o.match;
      end
    end
  end

  // Output register: a result waits here while the next request is taken.
  assign rec_x = {4'b0000, rec_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (req_q == cnsm_pkg::REQ_MATCH) begin
        out_kind_q <= 1'b1;
        out_data_q <= {3'b000, found_q ? rec_x[3:0] : 4'd0, found_q, 16'h0000};
      end else begin
        out_kind_q <= 1'b0;
        out_data_q <= {8'h00, hdr_mode_q, hdr_cat_q};
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  assign sts_o.req      = req_q;
  assign sts_o.idx_ok   = idx_ok;
  assign sts_o.pos_last = (pos_q == PW'(RECORD_BYTES - 1));
  assign sts_o.k_last   = (k_q == KW'(MATCH_CHARS - 1));
  assign sts_o.rec_last = (rec_q == EW'(ENTRIES - 1));
  assign sts_o.match    = !skip_q && (int'(cnt_q) >= MATCH_CHARS + 1) && eq_all;
  assign sts_o.out_busy = out_vld_q && !m_axis_tready;

endmodule

@@ sv/caller_number_suffix_match_core.sv @@
// Top level of the caller number suffix matcher: controller plus datapath.
// Write record byte and load caller byte are stored in the decode state; clear then writes each
// byte of the record in turn. A header read reads both header bytes and loads the result; a match
// loads the caller window, then scans each record's bytes from NUM_START until a match or the last record.
// One request is worked at a time; a finished result waits in the output register.
// rst_ni clears control state asynchronously; the stores hold no value until written.
module caller_number_suffix_match_core #(
  parameter int ENTRIES      = 15,
  parameter int RECORD_BYTES = 16,
  parameter int MATCH_CHARS  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // entry_index[3:0], byte_pos[7:4], byte_value[15:8]
  input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // category[7:0], mode[15:8], match_found[16],
                                     // match_index[20:17], zero[23:21]
  output logic        m_axis_tuser   // resp_kind[0]
);

  cnsm_pkg::cmd_t cmd;
  cnsm_pkg::sts_t sts;

  cnsm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  cnsm_dp #(
    .ENTRIES     (ENTRIES),
    .RECORD_BYTES(RECORD_BYTES),
    .MATCH_CHARS (MATCH_CHARS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

`ifndef NO_ASSERTIONS
  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !sts.out_busy) else $error("output overwritten");

  // After a transfer the block is busy for at least the decode cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("accept while busy");

  // Clearing writes happen only for a record that exists.
  a_clear_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_we |-> sts.idx_ok) else $error("clear out of range");

  // The RAM read port serves one purpose per cycle.
  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.hdr_rd0, cmd.hdr_rd1, cmd.scan_rd})) else $error("read port conflict");
`endif

endmodule

@@ test/tb_caller_number_suffix_match_core.sv @@
// Self-checking testbench for the caller number suffix matcher core.
module tb_caller_number_suffix_match_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES      = 15;
  localparam int RECORD_BYTES = 16;
  localparam int MATCH_CHARS  = 8;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_MATCH  = 1'b1;

  localparam int RANDOM_ITEMS = 430;
  localparam int MIN_ANSWERS  = 48;
  localparam int IDLE_PERCENT = 25;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 300;

  typedef logic [7:0] text_t [16];

  typedef struct {
    logic       kind;
    logic [7:0] category;
    logic [7:0] mode;
    logic       found;
    logic [3:0] index;
  } answer_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // entry_index[3:0], byte_pos[7:4], byte_value[15:8]
  logic [2:0]  s_axis_tuser  = '0;  // req_type[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // category[7:0], mode[15:8], match_found[16],
                                    // match_index[20:17], zero[23:21]
  logic        m_axis_tuser;        // resp_kind[0]

  logic [7:0] shadow_records [ENTRIES][RECORD_BYTES];
  logic [7:0] shadow_caller [cnsm_pkg::CALLER_BYTES];
  answer_t    pending_answers [$];

  bit calm = 1'b0;
  int items_sent = 0;
  int answers_expected = 0;
  int header_answers = 0;
  int match_answers = 0;
  int match_hits = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  caller_number_suffix_match_core #(
    .ENTRIES      (ENTRIES),
    .RECORD_BYTES (RECORD_BYTES),
    .MATCH_CHARS  (MATCH_CHARS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Returns the first record whose number ends in the caller suffix, or -1.
  function automatic int find_suffix_owner();
    int qpos, tail, stop, ci;
    bit ok;
    qpos = cnsm_pkg::CALLER_BYTES;
    for (int p = 1; p < cnsm_pkg::CALLER_BYTES; p++) begin
      if (shadow_caller[p] == cnsm_pkg::QUOTE_CHAR) begin
        qpos = p;
        break;
      end
    end
    tail = qpos - 1;
    for (int n = 0; n < ENTRIES; n++) begin
      if (shadow_records[n][cnsm_pkg::NUM_START] == cnsm_pkg::EMPTY_BYTE ||
          shadow_records[n][cnsm_pkg::NUM_START] == cnsm_pkg::NUL_CHAR) continue;
      stop = RECORD_BYTES;
      for (int p = cnsm_pkg::NUM_START; p < RECORD_BYTES; p++) begin
        if (shadow_records[n][p] == cnsm_pkg::QUOTE_CHAR ||
            shadow_records[n][p] == cnsm_pkg::NUL_CHAR) begin
          stop = p;
          break;
        end
      end
      if (stop - cnsm_pkg::NUM_START < MATCH_CHARS + 1) continue;
      ok = 1'b1;
      for (int k = 0; k < MATCH_CHARS; k++) begin
        ci = tail - k;
        if (ci < 0 || shadow_caller[ci] != shadow_records[n][stop - 1 - k]) begin
          ok = 1'b0;
          break;
        end
      end
      if (ok) return n;
    end
    return -1;
  endfunction

  // Updates the shadow tables for one accepted request and queues its answer for header and match requests.
  function automatic void predict_answer(input logic [2:0] req, input logic [3:0] idx,
                                         input logic [3:0] pos, input logic [7:0] val);
    answer_t ans;
    bit idx_ok;
    int owner;
    idx_ok = idx < ENTRIES;
    ans = '{kind: KIND_HEADER, category: 8'h00, mode: 8'h00, found: 1'b0, index: 4'h0};
    case (req)
      cnsm_pkg::REQ_WRITE: begin
        if (idx_ok && pos < RECORD_BYTES) shadow_records[idx][pos] = val;
      end
      cnsm_pkg::REQ_CLEAR: begin
        if (idx_ok) begin
          shadow_records[idx][0] = cnsm_pkg::ZERO_CHAR;
          shadow_records[idx][1] = cnsm_pkg::ZERO_CHAR;
          shadow_records[idx][cnsm_pkg::NUM_START] = cnsm_pkg::NUL_CHAR;
          for (int p = cnsm_pkg::NUM_START + 1; p < RECORD_BYTES; p++)
            shadow_records[idx][p] = cnsm_pkg::EMPTY_BYTE;
        end
      end
      cnsm_pkg::REQ_HEADER: begin
        if (idx_ok) begin
          ans.category = shadow_records[idx][0];
          ans.mode = shadow_records[idx][1];
        end
        pending_answers.push_back(ans);
        answers_expected++;
        header_answers++;
      end
      cnsm_pkg::REQ_CALLER: begin
        shadow_caller[pos] = val;
      end
      cnsm_pkg::REQ_MATCH: begin
        owner = find_suffix_owner();
        ans.kind = KIND_MATCH;
        if (owner >= 0) begin
          ans.found = 1'b1;
          ans.index = 4'(owner);
          match_hits++;
        end
        pending_answers.push_back(ans);
        answers_expected++;
        match_answers++;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", field, got, want));
  endtask

  task automatic check_answer();
    answer_t want;
    if (pending_answers.size() == 0) begin
      report_mismatch($sformatf("answer with none pending, tdata=%h tuser=%b",
                                m_axis_tdata, m_axis_tuser));
    end else begin
      want = pending_answers.pop_front();
      check_field("resp_kind", m_axis_tuser, want.kind);
      check_field("category", m_axis_tdata[7:0], want.category);
      check_field("mode", m_axis_tdata[15:8], want.mode);
      check_field("match_found", m_axis_tdata[16], want.found);
      check_field("match_index", m_axis_tdata[20:17], want.index);
    end
  endtask

  // Result side: check each transfer and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_answer();
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Ends the run when neither side has moved a transfer for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer.", idle_cycles);
      $display("tb_caller_number_suffix_match_core NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [2:0] req, input logic [3:0] idx,
                              input logic [3:0] pos, input logic [7:0] val);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {val, pos, idx};
    s_axis_tuser <= req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_answer(req, idx, pos, val);
    if (req <= cnsm_pkg::REQ_MATCH) items_sent++;
  endtask

  function automatic logic [7:0] rand_digit();
    return cnsm_pkg::ZERO_CHAR + 8'($urandom_range(9));
  endfunction

  function automatic text_t random_digits();
    text_t num;
    for (int p = 0; p < 16; p++) num[p] = rand_digit();
    return num;
  endfunction

  // A number of len digits whose last MATCH_CHARS digits are the caller suffix.
  function automatic text_t suffix_number(input text_t body, input int len);
    text_t num;
    for (int p = 0; p < 16; p++)
      num[p] = (p >= len - MATCH_CHARS) ? body[p - (len - MATCH_CHARS)] : rand_digit();
    return num;
  endfunction

  task automatic send_random_fields(input logic [2:0] req);
    send_request(req, 4'($urandom_range(15)), 4'($urandom_range(15)),
                 8'($urandom_range(255)));
  endtask

  // Loads a caller ID whose suffix sits just before a quote at quote_pos.
  task automatic load_caller(input text_t body, input int quote_pos);
    int lead;
    logic [7:0] val;
    lead = quote_pos - MATCH_CHARS;
    for (int p = 0; p < cnsm_pkg::CALLER_BYTES && p <= quote_pos; p++) begin
      if (p == quote_pos) val = cnsm_pkg::QUOTE_CHAR;
      else if (p >= lead) val = body[p - lead];
      else val = rand_digit();
      send_request(cnsm_pkg::REQ_CALLER, 4'($urandom_range(15)), 4'(p), val);
    end
  endtask

  task automatic store_record(input logic [3:0] idx, input text_t num, input int len,
                              input logic [7:0] term);
    for (int p = 0; p < len; p++)
      send_request(cnsm_pkg::REQ_WRITE, idx, 4'(cnsm_pkg::NUM_START + p), num[p]);
    if (cnsm_pkg::NUM_START + len < RECORD_BYTES)
      send_request(cnsm_pkg::REQ_WRITE, idx, 4'(cnsm_pkg::NUM_START + len), term);
  endtask

  // Every record byte and caller byte gets a defined value before any read.
  task automatic test_table_setup();
    for (int n = 0; n < ENTRIES; n++)
      send_request(cnsm_pkg::REQ_CLEAR, 4'(n), 4'($urandom_range(15)),
                   8'($urandom_range(255)));
    load_caller(random_digits(), cnsm_pkg::CALLER_BYTES);
  endtask

  task automatic test_header_requests();
    send_random_fields(cnsm_pkg::REQ_HEADER);
    send_request(cnsm_pkg::REQ_HEADER, 4'(0), 4'(0), 8'h00);
    send_request(cnsm_pkg::REQ_WRITE, 4'(ENTRIES - 1), 4'(0), 8'hFF);
    send_request(cnsm_pkg::REQ_WRITE, 4'(ENTRIES - 1), 4'(1), 8'h00);
    send_request(cnsm_pkg::REQ_WRITE, 4'(ENTRIES - 1), 4'(RECORD_BYTES - 1), 8'h00);
    send_request(cnsm_pkg::REQ_HEADER, 4'(ENTRIES - 1), 4'(RECORD_BYTES - 1), 8'hFF);
    // An index past the table is ignored by writes and reads back as zero.
    send_request(cnsm_pkg::REQ_WRITE, 4'(ENTRIES), 4'(0), 8'h55);
    send_request(cnsm_pkg::REQ_CLEAR, 4'(ENTRIES), 4'(0), 8'hAA);
    send_request(cnsm_pkg::REQ_HEADER, 4'(ENTRIES), 4'(RECORD_BYTES - 1), 8'hFF);
    send_request(cnsm_pkg::REQ_CALLER, 4'(ENTRIES), 4'(cnsm_pkg::CALLER_BYTES - 1), 8'hFF);
    for (int r = cnsm_pkg::REQ_MATCH + 1; r < 2 ** $bits(cnsm_pkg::REQ_MATCH); r++)
      send_random_fields(3'(r));
    send_request(cnsm_pkg::REQ_CLEAR, 4'(ENTRIES - 1), 4'(0), 8'h00);
    send_request(cnsm_pkg::REQ_HEADER, 4'(ENTRIES - 1), 4'(0), 8'h00);
  endtask

  task automatic test_match_cases();
    text_t body;
    body = random_digits();
    load_caller(body, 12);
    send_random_fields(cnsm_pkg::REQ_MATCH);
    store_record(4'(3), suffix_number(body, MATCH_CHARS + 1), MATCH_CHARS + 1,
                 cnsm_pkg::QUOTE_CHAR);
    // Only MATCH_CHARS digits: the suffix agrees but the number is too short.
    store_record(4'(1), body, MATCH_CHARS, cnsm_pkg::NUL_CHAR);
    send_random_fields(cnsm_pkg::REQ_MATCH);
    // A number that fills the record has no terminator at all.
    store_record(4'(0), suffix_number(body, RECORD_BYTES - cnsm_pkg::NUM_START),
                 RECORD_BYTES - cnsm_pkg::NUM_START, cnsm_pkg::NUL_CHAR);
    send_random_fields(cnsm_pkg::REQ_MATCH);
    send_request(cnsm_pkg::REQ_WRITE, 4'(0), 4'(cnsm_pkg::NUM_START), cnsm_pkg::EMPTY_BYTE);
    send_random_fields(cnsm_pkg::REQ_MATCH);
    load_caller(body, cnsm_pkg::CALLER_BYTES);
    send_random_fields(cnsm_pkg::REQ_MATCH);
    // A quote at caller position 0 is not taken as the closing quote.
    send_request(cnsm_pkg::REQ_CALLER, 4'(0), 4'(0), cnsm_pkg::QUOTE_CHAR);
    send_random_fields(cnsm_pkg::REQ_MATCH);
    // With an early quote the compared window runs off the buffer start.
    load_caller(body, 5);
    send_random_fields(cnsm_pkg::REQ_MATCH);
  endtask

  task automatic test_random_traffic();
    text_t body, num;
    int len, qpos, stop_at, answers_start;
    logic [3:0] idx;
    body = random_digits();
    stop_at = items_sent + RANDOM_ITEMS;
    answers_start = answers_expected;
    while (items_sent < stop_at || answers_expected - answers_start < MIN_ANSWERS) begin
      calm = items_sent >= stop_at - 350 && items_sent < stop_at - 230;
      if ($urandom_range(99) < 25) begin
        repeat ($urandom_range(1, 4)) send_random_fields(3'($urandom_range(7)));
      end else begin
        if ($urandom_range(1) == 1) begin
          body = random_digits();
          case ($urandom_range(9))
            0: qpos = $urandom_range(1, MATCH_CHARS - 1);
            1: qpos = cnsm_pkg::CALLER_BYTES;
            default: qpos = $urandom_range(MATCH_CHARS, cnsm_pkg::CALLER_BYTES - 1);
          endcase
          load_caller(body, qpos);
        end
        idx = 4'($urandom_range(ENTRIES - 1));
        if ($urandom_range(99) < 20) send_random_fields(cnsm_pkg::REQ_CLEAR);
        if ($urandom_range(1) == 1) begin
          send_request(cnsm_pkg::REQ_WRITE, idx, 4'(0), 8'($urandom_range(255)));
          send_request(cnsm_pkg::REQ_WRITE, idx, 4'(1), 8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 60) begin
          len = $urandom_range(MATCH_CHARS + 1, RECORD_BYTES - cnsm_pkg::NUM_START);
          num = suffix_number(body, len);
          if ($urandom_range(99) < 20) num[$urandom_range(len - 1)] = rand_digit();
        end else begin
          len = $urandom_range(RECORD_BYTES - cnsm_pkg::NUM_START);
          num = random_digits();
        end
        store_record(idx, num, len,
                     ($urandom_range(1) == 1) ? cnsm_pkg::QUOTE_CHAR : cnsm_pkg::NUL_CHAR);
        if ($urandom_range(99) < 30)
          send_request(cnsm_pkg::REQ_HEADER, 4'($urandom_range(ENTRIES)),
                       4'($urandom_range(15)), 8'($urandom_range(255)));
        send_random_fields(cnsm_pkg::REQ_MATCH);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_setup();
    test_header_requests();
    test_match_cases();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_answers.size() != 0)
      report_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));
    $display("Sent %0d requests; checked %0d header reads and %0d match scans (%0d hits).",
             items_sent, header_answers, match_answers, match_hits);
    $display("Mismatches found: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_caller_number_suffix_match_core OK");
    end else begin
      $display("tb_caller_number_suffix_match_core NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/cnsm_pkg.sv
sv/cnsm_ram.sv
sv/cnsm_ctrl.sv
sv/cnsm_dp.sv
sv/caller_number_suffix_match_core.sv
test/tb_caller_number_suffix_match_core.sv
